// ----- hw/rtl/bsf_pkg.sv -----
// bsf_pkg: shared widths, register indexes, reset values and saturating helpers
// for the brush stroke filter; no dependencies
`default_nettype none

package bsf_pkg;

   localparam int FRAC_DEF   = 16;
   localparam int DATA_W     = 32;
   localparam int KEEP_W     = 17;
   localparam int BASE_W     = 21;
   localparam int GAIN_W     = 21;
   localparam int MINW_W     = 17;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam int KEEP_SHIFT = 16;

   // register indexes on the csr port
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_DRAG_KEEP  = 8'd0,
      REG_WIDTH_BASE = 8'd1,
      REG_WIDTH_GAIN = 8'd2,
      REG_MIN_WIDTH  = 8'd3
   } reg_index_type;

   // item kinds on req_tuser
   localparam logic KIND_SET    = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic [KEEP_W-1:0] KEEP_RST = KEEP_W'(26214);
   localparam logic [BASE_W-1:0] BASE_RST = BASE_W'(2621);
   localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(98304);
   localparam logic [MINW_W-1:0] MINW_RST = MINW_W'(1);

   localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

   function automatic logic [DATA_W-1:0] sat33(input logic [DATA_W:0] s);
      logic [DATA_W-1:0] r;
      if (s[DATA_W] != s[DATA_W-1]) begin
         r = s[DATA_W] ? S32_MIN : S32_MAX;
      end else begin
         r = s[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] add_sat(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      return sat33({a[DATA_W-1], a} + {b[DATA_W-1], b});
   endfunction

   function automatic logic [DATA_W-1:0] sub_sat(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      return sat33({a[DATA_W-1], a} - {b[DATA_W-1], b});
   endfunction

   // magnitude of a signed word, -2^31 gives 2^31
   function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? (~v + 1'b1) : v;
   endfunction

   // sign and magnitude to a saturated signed word
   function automatic logic [DATA_W-1:0] sat_mag(input logic neg, input logic [63:0] m);
      logic [DATA_W-1:0] r;
      if (!neg) begin
         r = (m > 64'(S32_MAX)) ? S32_MAX : m[DATA_W-1:0];
      end else begin
         r = (m >= 64'(S32_MIN)) ? S32_MIN : (~m[DATA_W-1:0] + 1'b1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/brush_stroke_filter.sv -----
// brush_stroke_filter: drag-damped pen follower emitting brush stroke quads
// depends on bsf_pkg; one shared multiplier plus a shared sqrt/divide step unit
//
//   channel   ports                                  contents
//   req       req_tvalid req_tready req_tdata        point_x [31:0], point_y [63:32]
//             req_tuser                              kind (0 set pen, 1 sample)
//   rsp       rsp_tvalid rsp_tready rsp_tdata        vertex_x [31:0], vertex_y [63:32]
//             rsp_tlast                              last_corner
//   csr       csr_valid csr_ready csr_addr csr_data  register index, write data
//
// a set item only loads the pen and clears its velocity, and the block stays idle; a sample item
// that moves the pen passes through the square root and the two (32+FRAC_BITS)-step
// divisions (FRAC_BITS 16 gives Q16.16) before its four corners
// req_tready is high only while idle; rsp stalls simply hold the current corner
// reset is synchronous, active high, and loads the register defaults and a
// zero pen state
`default_nettype none

module brush_stroke_filter import bsf_pkg::*; #(
   parameter int FRAC_BITS = FRAC_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [2*DATA_W-1:0]   req_tdata,   // point_x, point_y
   input  wire logic                  req_tuser,   // kind
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [2*DATA_W-1:0]        rsp_tdata,   // vertex_x, vertex_y
   output logic                       rsp_tlast,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int WID_W  = BASE_W + GAIN_W - FRAC_BITS;
   localparam int MB_W   = (WID_W > DATA_W) ? WID_W : DATA_W;
   localparam int PROD_W = DATA_W + MB_W;
   localparam int NUM_W  = DATA_W + FRAC_BITS;
   localparam int CNT_W  = $clog2(NUM_W + 1);
   localparam int HMAG_W = FRAC_BITS + 1;

   typedef enum logic [14:0] {
      ST_IDLE   = 15'b000000000000001,
      ST_SQX    = 15'b000000000000010,
      ST_SQY    = 15'b000000000000100,
      ST_SQADD  = 15'b000000000001000,
      ST_SQRT   = 15'b000000000010000,
      ST_DIVX   = 15'b000000000100000,
      ST_DIVY   = 15'b000000001000000,
      ST_WMUL   = 15'b000000010000000,
      ST_WCLAMP = 15'b000000100000000,
      ST_OFSX   = 15'b000001000000000,
      ST_OFSY   = 15'b000010000000000,
      ST_DRAGX  = 15'b000100000000000,
      ST_DRAGY  = 15'b001000000000000,
      ST_MOVE   = 15'b010000000000000,
      ST_EMIT   = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [KEEP_W-1:0] keep_ff, keep_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [MINW_W-1:0] minw_ff, minw_in;

   // pen state
   logic [DATA_W-1:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic [DATA_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [DATA_W-1:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic [DATA_W-1:0] off_x_ff, off_x_in, off_y_ff, off_y_in;

   // working registers
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [63:0]       rad_ff, rad_in, root_ff, root_in, bit_ff, bit_in;
   logic [DATA_W-1:0] speed_ff, speed_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [HMAG_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [HMAG_W-1:0] hx_mag_ff, hx_mag_in, hy_mag_ff, hy_mag_in;
   logic              hx_neg_ff, hx_neg_in, hy_neg_ff, hy_neg_in;
   logic [WID_W-1:0]  wid_ff, wid_in;
   logic [DATA_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [1:0]        corner_ff, corner_in;

   logic [DATA_W-1:0] mul_a;
   logic [MB_W-1:0]   mul_b;
   logic [DATA_W-1:0] pt_x, pt_y, fx, fy;
   logic [DATA_W:0]   diff, div_trial;
   logic              diff_pos, div_ge;
   logic [63:0]       sq_trial;
   logic [WID_W-1:0]  wid_raw;
   logic [DATA_W-1:0] vy_new;
   logic [DATA_W-1:0] vx_out, vy_out;
   logic              req_fire, rsp_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   assign pt_x = req_tdata[DATA_W-1:0];
   assign pt_y = req_tdata[2*DATA_W-1:DATA_W];
   assign fx   = sub_sat(pt_x, pen_x_ff);
   assign fy   = sub_sat(pt_y, pen_y_ff);

   // width before clamping: base minus speed, only its positive side matters
   assign diff     = {{(DATA_W+1-BASE_W){1'b0}}, base_ff} - {1'b0, speed_ff};
   assign diff_pos = !diff[DATA_W] && (diff != '0);
   assign wid_raw  = WID_W'(prod_ff >> FRAC_BITS);

   // shared step unit: sqrt trial and restoring divide trial
   assign sq_trial  = root_ff + bit_ff;
   assign div_trial = {rem_ff, num_ff[NUM_W-1]};
   assign div_ge    = (div_trial >= {1'b0, speed_ff});

   assign vy_new = sat_mag(vel_y_ff[DATA_W-1], 64'(prod_ff >> KEEP_SHIFT));

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQX: begin
            mul_a = mag32(vel_x_ff);
            mul_b = MB_W'(mag32(vel_x_ff));
         end
         ST_SQY: begin
            mul_a = mag32(vel_y_ff);
            mul_b = MB_W'(mag32(vel_y_ff));
         end
         ST_WMUL: begin
            mul_a = DATA_W'(diff[BASE_W-1:0]);
            mul_b = MB_W'(gain_ff);
         end
         ST_OFSX: begin
            mul_a = DATA_W'(hx_mag_ff);
            mul_b = MB_W'(wid_ff);
         end
         ST_OFSY: begin
            mul_a = DATA_W'(hy_mag_ff);
            mul_b = MB_W'(wid_ff);
         end
         ST_DRAGX: begin
            mul_a = mag32(vel_x_ff);
            mul_b = MB_W'(keep_ff);
         end
         ST_DRAGY: begin
            mul_a = mag32(vel_y_ff);
            mul_b = MB_W'(keep_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      keep_in   = keep_ff;
      base_in   = base_ff;
      gain_in   = gain_ff;
      minw_in   = minw_ff;
      pen_x_in  = pen_x_ff;
      pen_y_in  = pen_y_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      vel_x_in  = vel_x_ff;
      vel_y_in  = vel_y_ff;
      off_x_in  = off_x_ff;
      off_y_in  = off_y_ff;
      rad_in    = rad_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      speed_in  = speed_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      hx_mag_in = hx_mag_ff;
      hy_mag_in = hy_mag_ff;
      hx_neg_in = hx_neg_ff;
      hy_neg_in = hy_neg_ff;
      wid_in    = wid_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      corner_in = corner_ff;

      if (csr_valid && csr_ready) begin
         if (csr_addr == REG_DRAG_KEEP) begin
            keep_in = csr_data[KEEP_W-1:0];
         end else if (csr_addr == REG_WIDTH_BASE) begin
            base_in = csr_data[BASE_W-1:0];
         end else if (csr_addr == REG_WIDTH_GAIN) begin
            gain_in = csr_data[GAIN_W-1:0];
         end else if (csr_addr == REG_MIN_WIDTH) begin
            minw_in = csr_data[MINW_W-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == KIND_SET) begin
                  pen_x_in  = pt_x;
                  pen_y_in  = pt_y;
                  prev_x_in = pt_x;
                  prev_y_in = pt_y;
                  vel_x_in  = '0;
                  vel_y_in  = '0;
               end else if (fx != '0 || fy != '0) begin
                  vel_x_in = add_sat(vel_x_ff, fx);
                  vel_y_in = add_sat(vel_y_ff, fy);
                  state_in = ST_SQX;
               end
            end
         end
         ST_SQX: state_in = ST_SQY;
         ST_SQY: begin
            rad_in   = prod_ff[63:0];
            state_in = ST_SQADD;
         end
         ST_SQADD: begin
            rad_in   = rad_ff + prod_ff[63:0];
            root_in  = '0;
            bit_in   = 64'd1 << 62;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (bit_ff != '0) begin
               if (rad_ff >= sq_trial) begin
                  rad_in  = rad_ff - sq_trial;
                  root_in = (root_ff >> 1) + bit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end else begin
               speed_in = root_ff[DATA_W-1:0];
               if (root_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  // heading x is -vel_y / speed
                  num_in   = {mag32(vel_y_ff), {FRAC_BITS{1'b0}}};
                  rem_in   = '0;
                  quo_in   = '0;
                  cnt_in   = CNT_W'(NUM_W);
                  state_in = ST_DIVX;
               end
            end
         end
         ST_DIVX, ST_DIVY: begin
            if (cnt_ff != '0) begin
               rem_in = div_ge ? DATA_W'(div_trial - {1'b0, speed_ff})
                               : div_trial[DATA_W-1:0];
               quo_in = {quo_ff[HMAG_W-2:0], div_ge};
               num_in = num_ff << 1;
               cnt_in = cnt_ff - 1'b1;
            end else if (state_ff == ST_DIVX) begin
               hx_mag_in = quo_ff;
               hx_neg_in = !vel_y_ff[DATA_W-1] && (vel_y_ff != '0);
               num_in    = {mag32(vel_x_ff), {FRAC_BITS{1'b0}}};
               rem_in    = '0;
               quo_in    = '0;
               cnt_in    = CNT_W'(NUM_W);
               state_in  = ST_DIVY;
            end else begin
               hy_mag_in = quo_ff;
               hy_neg_in = vel_x_ff[DATA_W-1];
               state_in  = ST_WMUL;
            end
         end
         ST_WMUL: state_in = ST_WCLAMP;
         ST_WCLAMP: begin
            if (!diff_pos || wid_raw < WID_W'(minw_ff)) begin
               wid_in = WID_W'(minw_ff);
            end else begin
               wid_in = wid_raw;
            end
            state_in = ST_OFSX;
         end
         ST_OFSX: state_in = ST_OFSY;
         ST_OFSY: begin
            dx_in    = sat_mag(hx_neg_ff, 64'(prod_ff >> FRAC_BITS));
            state_in = ST_DRAGX;
         end
         ST_DRAGX: begin
            dy_in    = sat_mag(hy_neg_ff, 64'(prod_ff >> FRAC_BITS));
            state_in = ST_DRAGY;
         end
         ST_DRAGY: begin
            vel_x_in = sat_mag(vel_x_ff[DATA_W-1], 64'(prod_ff >> KEEP_SHIFT));
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            vel_y_in  = vy_new;
            prev_x_in = pen_x_ff;
            prev_y_in = pen_y_ff;
            pen_x_in  = add_sat(pen_x_ff, vel_x_ff);
            pen_y_in  = add_sat(pen_y_ff, vy_new);
            corner_in = '0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               corner_in = corner_ff + 1'b1;
               if (corner_ff == 2'd3) begin
                  off_x_in = dx_ff;
                  off_y_in = dy_ff;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // corner order: old pair around prev, new pair around pen
   always_comb begin
      unique case (corner_ff)
         2'd0: begin
            vx_out = add_sat(prev_x_ff, off_x_ff);
            vy_out = add_sat(prev_y_ff, off_y_ff);
         end
         2'd1: begin
            vx_out = sub_sat(prev_x_ff, off_x_ff);
            vy_out = sub_sat(prev_y_ff, off_y_ff);
         end
         2'd2: begin
            vx_out = sub_sat(pen_x_ff, dx_ff);
            vy_out = sub_sat(pen_y_ff, dy_ff);
         end
         default: begin
            vx_out = add_sat(pen_x_ff, dx_ff);
            vy_out = add_sat(pen_y_ff, dy_ff);
         end
      endcase
   end

   assign rsp_tdata = {vy_out, vx_out};
   assign rsp_tlast = (corner_ff == 2'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         keep_ff   <= KEEP_RST;
         base_ff   <= BASE_RST;
         gain_ff   <= GAIN_RST;
         minw_ff   <= MINW_RST;
         pen_x_ff  <= '0;
         pen_y_ff  <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         vel_x_ff  <= '0;
         vel_y_ff  <= '0;
         off_x_ff  <= '0;
         off_y_ff  <= '0;
         corner_ff <= '0;
      end else begin
         state_ff  <= state_in;
         keep_ff   <= keep_in;
         base_ff   <= base_in;
         gain_ff   <= gain_in;
         minw_ff   <= minw_in;
         pen_x_ff  <= pen_x_in;
         pen_y_ff  <= pen_y_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         vel_x_ff  <= vel_x_in;
         vel_y_ff  <= vel_y_in;
         off_x_ff  <= off_x_in;
         off_y_ff  <= off_y_in;
         corner_ff <= corner_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      rad_ff    <= rad_in;
      root_ff   <= root_in;
      bit_ff    <= bit_in;
      speed_ff  <= speed_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      hx_mag_ff <= hx_mag_in;
      hy_mag_ff <= hy_mag_in;
      hx_neg_ff <= hx_neg_in;
      hy_neg_ff <= hy_neg_in;
      wid_ff    <= wid_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/bsf_checker.sv -----
// bsf_checker: port-level assertions for the brush stroke filter
// depends on bsf_pkg; bound to brush_stroke_filter below
`default_nettype none

module bsf_checker import bsf_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [2*DATA_W-1:0]   rsp_tdata,
   input wire logic                  rsp_tlast
);

   // no new item while corners are pending
   a_busy_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("req_tready high while a corner waits");

   // a set item never produces corners
   a_set_silent: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == KIND_SET) |=> !rsp_tvalid)
      else $error("corner after a set item");

   // the last corner closes the quad
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("corner after the last one of a quad");

   // a stalled corner holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tlast)))
      else $error("stalled corner changed");

endmodule

bind brush_stroke_filter bsf_checker u_bsf_checker (.*);

`default_nettype wire

// ----- tb/sv/brush_stroke_filter_test.sv -----
// brush_stroke_filter_test: self-checking bench for the brush stroke filter
// depends on bsf_pkg and brush_stroke_filter; predicts quad corners per sample item
`timescale 1ns / 1ps

module brush_stroke_filter_test;
   import bsf_pkg::*;

   typedef struct packed {
      logic        kind;
      logic [31:0] px;
      logic [31:0] py;
   } point_item_type;

   typedef struct packed {
      logic [31:0] vx;
      logic [31:0] vy;
      logic        last;
   } corner_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   brush_stroke_filter u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_addr(csr_addr), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // pen model state and register copies
   longint pen_x, pen_y, prev_x, prev_y, vel_x, vel_y, off_x, off_y;
   longint unsigned keep_r, base_r, gain_r, minw_r;

   point_item_type pending_items[$];
   corner_type     corners_due[$];
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_off = 0;
   int  errors = 0;
   longint cycles = 0;

   // the acceptance seen at the last rising edge
   logic req_tready_seen = 1'b0;

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned absval(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   // product shifted right, truncated toward zero
   function automatic longint scale_trunc(longint a, longint b, int sh);
      longint unsigned p;
      p = (absval(a) * absval(b)) >> sh;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic corner_type mk_corner(longint x, longint y, logic last);
      corner_type c;
      c.vx = 32'(clip32(x));
      c.vy = 32'(clip32(y));
      c.last = last;
      return c;
   endfunction

   // advance the pen model by one item and queue the corners it produces
   task automatic predict_stroke(point_item_type it);
      longint px, py, fx, fy, hx, hy, wid, dx, dy, diff;
      longint unsigned speed, q;
      px = longint'($signed(it.px));
      py = longint'($signed(it.py));
      if (it.kind == KIND_SET) begin
         pen_x = px; prev_x = px; pen_y = py; prev_y = py;
         vel_x = 0; vel_y = 0;
         return;
      end
      fx = clip32(px - pen_x);
      fy = clip32(py - pen_y);
      if (fx == 0 && fy == 0) return;
      vel_x = clip32(vel_x + fx);
      vel_y = clip32(vel_y + fy);
      speed = int_root(absval(vel_x) * absval(vel_x) + absval(vel_y) * absval(vel_y));
      if (speed == 0) return;
      q = (absval(vel_y) << 16) / speed;
      hx = (vel_y > 0) ? -longint'(q) : longint'(q);
      q = (absval(vel_x) << 16) / speed;
      hy = (vel_x < 0) ? -longint'(q) : longint'(q);
      diff = longint'(base_r) - longint'(speed);
      if (diff <= 0) wid = minw_r;
      else begin
         wid = scale_trunc(diff, gain_r, 16);
         if (wid < longint'(minw_r)) wid = minw_r;
      end
      dx = clip32(scale_trunc(hx, wid, 16));
      dy = clip32(scale_trunc(hy, wid, 16));
      vel_x = clip32(scale_trunc(vel_x, keep_r, 16));
      vel_y = clip32(scale_trunc(vel_y, keep_r, 16));
      prev_x = pen_x; prev_y = pen_y;
      pen_x = clip32(pen_x + vel_x);
      pen_y = clip32(pen_y + vel_y);
      corners_due.insert(corners_due.size(), mk_corner(prev_x + off_x, prev_y + off_y, 1'b0));
      corners_due.insert(corners_due.size(), mk_corner(prev_x - off_x, prev_y - off_y, 1'b0));
      corners_due.insert(corners_due.size(), mk_corner(pen_x - dx, pen_y - dy, 1'b0));
      corners_due.insert(corners_due.size(), mk_corner(pen_x + dx, pen_y + dy, 1'b1));
      off_x = dx; off_y = dy;
   endtask

   // driver: presents the queue head, changes only on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready_seen) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_items[0].kind;
               req_tdata  <= {pending_items[0].py, pending_items[0].px};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= (hold_off == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // receiver hold-off countdown
   always @(posedge clock) begin
      if (hold_off > 0) hold_off <= hold_off - 1;
   end

   // monitor: accept items into the model and check corners
   always @(posedge clock) begin
      corner_type got, want;
      cycles <= cycles + 1;
      req_tready_seen <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_stroke(pending_items.pop_front());
         end
         if (rsp_tvalid && rsp_tready) begin
            got.vx = rsp_tdata[31:0];
            got.vy = rsp_tdata[63:32];
            got.last = rsp_tlast;
            if (corners_due.size() == 0) begin
               $error("corner with nothing expected: %h %h", got.vx, got.vy);
               errors++;
            end else begin
               want = corners_due.pop_front();
               if (got.vx !== want.vx) begin
                  $error("vertex_x expected %h got %h", want.vx, got.vx); errors++;
               end
               if (got.vy !== want.vy) begin
                  $error("vertex_y expected %h got %h", want.vy, got.vy); errors++;
               end
               if (got.last !== want.last) begin
                  $error("last_corner expected %b got %b", want.last, got.last); errors++;
               end
            end
         end
      end
      if (cycles > 3000000) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [31:0] rnd_coord();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom();
         default: return 32'($signed($urandom_range(40 << 16)) - (20 << 16));
      endcase
   endfunction

   task automatic add_item(logic kind, logic [31:0] x, logic [31:0] y);
      point_item_type it;
      it.kind = kind; it.px = x; it.py = y;
      pending_items.insert(pending_items.size(), it);
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_tvalid || corners_due.size() != 0)
         @(posedge clock);
      // a sample that emits nothing can still be busy for the block's latency
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, longint unsigned val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_data  <= 32'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_DRAG_KEEP:  keep_r = val & 64'h1FFFF;
         REG_WIDTH_BASE: base_r = val & 64'h1FFFFF;
         REG_WIDTH_GAIN: gain_r = val & 64'h1FFFFF;
         default:        minw_r = val & 64'h1FFFF;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stroke phase: mostly nearby samples, with occasional sets and random items
   task automatic random_strokes(int n);
      logic [31:0] bx, by;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) add_item(1'($urandom_range(1)), rnd_coord(), rnd_coord());
         else if ($urandom_range(7) == 0) begin
            bx = rnd_coord(); by = rnd_coord();
            add_item(KIND_SET, bx, by);
         end else begin
            add_item(KIND_SAMPLE, 32'($signed($urandom_range(200 << 16)) - (100 << 16)),
                     32'($signed($urandom_range(200 << 16)) - (100 << 16)));
         end
      end
   endtask

   initial begin
      keep_r = 26214; base_r = 2621; gain_r = 98304; minw_r = 1;
      pen_x = 0; pen_y = 0; prev_x = 0; prev_y = 0;
      vel_x = 0; vel_y = 0; off_x = 0; off_y = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: repeated point, zero move, extremes, saturation
      add_item(KIND_SAMPLE, 32'h0, 32'h0);
      add_item(KIND_SAMPLE, 32'h0001_0000, 32'h0);
      add_item(KIND_SAMPLE, 32'h0001_0000, 32'h0002_0000);
      add_item(KIND_SET, 32'h0010_0000, 32'hFFF0_0000);
      add_item(KIND_SAMPLE, 32'h0010_0000, 32'hFFF0_0000);
      add_item(KIND_SAMPLE, 32'h0010_0001, 32'hFFF0_0000);
      add_item(KIND_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000);
      add_item(KIND_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF);
      add_item(KIND_SET, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_item(KIND_SAMPLE, 32'h8000_0000, 32'h8000_0000);
      add_item(KIND_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_item(KIND_SET, 32'h0, 32'h0);
      add_item(KIND_SAMPLE, 32'h0000_0001, 32'h0000_0001);
      add_item(KIND_SAMPLE, 32'h0000_0800, 32'hFFFF_F800);
      wait_drained();

      // extreme registers, long receiver hold-off while items keep coming
      write_reg(REG_DRAG_KEEP, 65536);
      write_reg(REG_WIDTH_BASE, 1048576);
      write_reg(REG_WIDTH_GAIN, 1048576);
      write_reg(REG_MIN_WIDTH, 65536);
      hold_off = 2000;
      random_strokes(30);
      wait_drained();

      write_reg(REG_DRAG_KEEP, 0);
      write_reg(REG_WIDTH_BASE, 0);
      write_reg(REG_WIDTH_GAIN, 0);
      write_reg(REG_MIN_WIDTH, 0);
      send_idle_pct = 49;
      random_strokes(50);
      wait_drained();

      write_reg(REG_DRAG_KEEP, 131071);
      write_reg(REG_WIDTH_BASE, 2097151);
      write_reg(REG_WIDTH_GAIN, 2097151);
      write_reg(REG_MIN_WIDTH, 131071);
      send_idle_pct = 0; recv_idle_pct = 49;
      random_strokes(50);
      wait_drained();

      write_reg(REG_DRAG_KEEP, $urandom_range(65536));
      write_reg(REG_WIDTH_BASE, 1 << $urandom_range(20));
      write_reg(REG_WIDTH_GAIN, $urandom_range(1048576));
      write_reg(REG_MIN_WIDTH, $urandom_range(65536));
      send_idle_pct = 34; recv_idle_pct = 34;
      random_strokes(60);
      wait_drained();

      send_idle_pct = 0; recv_idle_pct = 0;
      write_reg(REG_DRAG_KEEP, 26214);
      write_reg(REG_WIDTH_BASE, 2621);
      write_reg(REG_WIDTH_GAIN, 98304);
      write_reg(REG_MIN_WIDTH, 1);
      random_strokes(60);
      wait_drained();

      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/bsf_pkg.sv
hw/rtl/brush_stroke_filter.sv
hw/rtl/bsf_checker.sv
tb/sv/brush_stroke_filter_test.sv
